// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level of the heading PID controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define HPID_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("heading PID assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define HPID_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("heading PID assertion failed");

`endif

// ----- rtl/hpid_pkg.sv -----
// Shared widths, constants, register indexes and types of the heading PID controller.
package hpid_pkg;

    localparam int SUM_WIDTH  = 24;
    localparam int HEAD_W     = 16;
    localparam int ERR_W      = 18;
    localparam int MAG_W      = ERR_W - 1;
    localparam int DIFF_W     = ERR_W + 1;
    localparam int GAIN_W     = 16;
    localparam int ZONE_W     = 9;
    localparam int LIMIT_W    = 15;
    localparam int POWER_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int HALF_TURN  = 180;
    localparam int FULL_TURN  = 360;
    localparam int ERR_MAX    = 65175;

    localparam int SUMX_W = ((SUM_WIDTH > ERR_W) ? SUM_WIDTH : ERR_W) + 1;
    localparam int PP_W   = GAIN_W + 1 + ERR_W;
    localparam int PI_W   = GAIN_W + 1 + SUM_WIDTH;
    localparam int PD_W   = GAIN_W + 1 + DIFF_W;
    localparam int ACC_W  = ((PI_W > PD_W) ? PI_W : PD_W) + 2;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_ZONE  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_POWER_LIMIT = CFG_IDX_W'(4);

    localparam logic [GAIN_W-1:0]  RST_PROP_GAIN   = GAIN_W'(492);
    localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN  = GAIN_W'(20);
    localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN  = GAIN_W'(246);
    localparam logic [ZONE_W-1:0]  RST_INTEG_ZONE  = ZONE_W'(15);
    localparam logic [LIMIT_W-1:0] RST_POWER_LIMIT = LIMIT_W'(24576);

    typedef struct packed {
        logic signed [ERR_W-1:0]     err;
        logic signed [DIFF_W-1:0]    diff;
        logic signed [SUM_WIDTH-1:0] sum;
    } t_err_res;

endpackage

// ----- rtl/hpid_err_unit.sv -----
// Heading error with half-turn wrap, zoned saturating integral and error difference.
module hpid_err_unit (
    input  logic signed [hpid_pkg::HEAD_W-1:0]    i_meas,
    input  logic signed [hpid_pkg::HEAD_W-1:0]    i_targ,
    input  logic        [hpid_pkg::ZONE_W-1:0]    i_zone,
    input  logic signed [hpid_pkg::ERR_W-1:0]     i_last_err,
    input  logic signed [hpid_pkg::SUM_WIDTH-1:0] i_sum,
    output hpid_pkg::t_err_res                    o_res
);
    import hpid_pkg::*;

    localparam logic signed [ERR_W-1:0] HALF_POS = ERR_W'(HALF_TURN);
    localparam logic signed [ERR_W-1:0] HALF_NEG = -ERR_W'(HALF_TURN);
    localparam logic signed [ERR_W-1:0] FULL     = ERR_W'(FULL_TURN);
    localparam logic [SUM_WIDTH-1:0]    SUM_HI   = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic [SUM_WIDTH-1:0]    SUM_LO   = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    logic signed [ERR_W-1:0]  raw;
    logic signed [ERR_W-1:0]  wrapped;
    logic signed [ERR_W-1:0]  neg;
    logic        [MAG_W-1:0]  mag;
    logic                     in_zone;
    logic signed [SUMX_W-1:0] sumx;
    logic [SUMX_W-SUM_WIDTH:0] top;

    always_comb begin
        raw = ERR_W'(i_targ) - ERR_W'(i_meas);
        if (raw > HALF_POS) begin
            wrapped = raw - FULL;
        end else if (raw < HALF_NEG) begin
            wrapped = raw + FULL;
        end else begin
            wrapped = raw;
        end
        neg     = -wrapped;
        mag     = wrapped[ERR_W-1] ? neg[MAG_W-1:0] : wrapped[MAG_W-1:0];
        in_zone = mag < MAG_W'(i_zone);

        sumx = SUMX_W'(i_sum) + SUMX_W'(wrapped);
        top  = sumx[SUMX_W-1:SUM_WIDTH-1];

        o_res.err  = wrapped;
        o_res.diff = DIFF_W'(wrapped) - DIFF_W'(i_last_err);
        if (!in_zone) begin
            o_res.sum = '0;
        end else if ((&top) || !(|top)) begin
            o_res.sum = sumx[SUM_WIDTH-1:0];
        end else if (sumx[SUMX_W-1]) begin
            o_res.sum = SUM_LO;
        end else begin
            o_res.sum = SUM_HI;
        end
    end

endmodule

// ----- rtl/hpid_out_unit.sv -----
// Sum of the three PID terms and the symmetric clamp to the power limit.
module hpid_out_unit (
    input  logic signed [hpid_pkg::PP_W-1:0]    i_pp,
    input  logic signed [hpid_pkg::PI_W-1:0]    i_pi,
    input  logic signed [hpid_pkg::PD_W-1:0]    i_pd,
    input  logic        [hpid_pkg::LIMIT_W-1:0] i_limit,
    output logic signed [hpid_pkg::POWER_W-1:0] o_power,
    output logic                                o_clamped
);
    import hpid_pkg::*;

    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] lim_pos;
    logic signed [ACC_W-1:0] lim_neg;

    always_comb begin
        acc     = ACC_W'(i_pp) + ACC_W'(i_pi) + ACC_W'(i_pd);
        lim_pos = $signed({{(ACC_W-LIMIT_W){1'b0}}, i_limit});
        lim_neg = -lim_pos;
        if (acc > lim_pos) begin
            o_power   = lim_pos[POWER_W-1:0];
            o_clamped = 1'b1;
        end else if (acc < lim_neg) begin
            o_power   = lim_neg[POWER_W-1:0];
            o_clamped = 1'b1;
        end else begin
            o_power   = acc[POWER_W-1:0];
            o_clamped = 1'b0;
        end
    end

endmodule

// ----- rtl/heading_pid_controller.sv -----
// Top level of the heading PID controller: configuration registers and four-stage pipeline.
//
//   Channel   Valid         Stall         Payload
//   request   i_in_valid    o_in_stall    i_measured_heading, i_target_heading
//   result    o_out_valid   i_out_stall   o_drive_power, o_clamped
//   config    i_cfg_we      (none)        i_cfg_idx, i_cfg_data
//
// A result is valid once its request has passed the input, error and integral, product
// and result registers, and one request is taken every cycle while o_in_stall is low.
// The stages are the input register, the error and integral register, the product
// register and the clamped result register.
// Reset clears the stage valid bits, the integral and the previous error, and
// restores the default gains, zone and limit.
// A stalled result holds the result register; earlier stages keep filling, and the
// request side stalls only when all four stages hold requests.
module heading_pid_controller (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [hpid_pkg::HEAD_W-1:0]    i_measured_heading,
    input  logic signed [hpid_pkg::HEAD_W-1:0]    i_target_heading,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [hpid_pkg::POWER_W-1:0]   o_drive_power,
    output logic                                  o_clamped,
    input  logic                                  i_cfg_we,
    input  logic        [hpid_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic        [hpid_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import hpid_pkg::*;

    `include "assert_macros.svh"

    logic [GAIN_W-1:0]  r_prop_gain;
    logic [GAIN_W-1:0]  r_integ_gain;
    logic [GAIN_W-1:0]  r_deriv_gain;
    logic [ZONE_W-1:0]  r_integ_zone;
    logic [LIMIT_W-1:0] r_power_limit;

    logic r_v0;
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic free0;
    logic free1;
    logic free2;
    logic adv3;

    logic signed [HEAD_W-1:0]    r_meas;
    logic signed [HEAD_W-1:0]    r_targ;
    logic signed [ERR_W-1:0]     r_err;
    logic signed [SUM_WIDTH-1:0] r_sum;
    logic signed [DIFF_W-1:0]    r_diff;
    t_err_res                    err_res;

    logic signed [PP_W-1:0] r_pp;
    logic signed [PI_W-1:0] r_pi;
    logic signed [PD_W-1:0] r_pd;
    logic signed [PP_W-1:0] n_pp;
    logic signed [PI_W-1:0] n_pi;
    logic signed [PD_W-1:0] n_pd;

    logic signed [POWER_W-1:0] r_drive_power;
    logic                      r_clamped;
    logic signed [POWER_W-1:0] n_drive_power;
    logic                      n_clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain   <= RST_PROP_GAIN;
            r_integ_gain  <= RST_INTEG_GAIN;
            r_deriv_gain  <= RST_DERIV_GAIN;
            r_integ_zone  <= RST_INTEG_ZONE;
            r_power_limit <= RST_POWER_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PROP_GAIN:   r_prop_gain   <= i_cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN:  r_integ_gain  <= i_cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN:  r_deriv_gain  <= i_cfg_data[GAIN_W-1:0];
                REG_INTEG_ZONE:  r_integ_zone  <= i_cfg_data[ZONE_W-1:0];
                REG_POWER_LIMIT: r_power_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign adv3       = !r_v3 || !i_out_stall;
    assign free2      = !r_v2 || adv3;
    assign free1      = !r_v1 || free2;
    assign free0      = !r_v0 || free1;
    assign o_in_stall = !free0;

    hpid_err_unit u_err (
        .i_meas     (r_meas),
        .i_targ     (r_targ),
        .i_zone     (r_integ_zone),
        .i_last_err (r_err),
        .i_sum      (r_sum),
        .o_res      (err_res)
    );

    always_comb begin
        n_pp = $signed({1'b0, r_prop_gain}) * r_err;
        n_pi = $signed({1'b0, r_integ_gain}) * r_sum;
        n_pd = $signed({1'b0, r_deriv_gain}) * r_diff;
    end

    hpid_out_unit u_out (
        .i_pp      (r_pp),
        .i_pi      (r_pi),
        .i_pd      (r_pd),
        .i_limit   (r_power_limit),
        .o_power   (n_drive_power),
        .o_clamped (n_clamped)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0  <= 1'b0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_err <= '0;
            r_sum <= '0;
        end else begin
            if (free0) begin
                r_v0 <= i_in_valid;
            end
            if (free1) begin
                r_v1 <= r_v0;
            end
            if (free2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
            if (r_v0 && free1) begin
                r_err <= err_res.err;
                r_sum <= err_res.sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && free0) begin
            r_meas <= i_measured_heading;
            r_targ <= i_target_heading;
        end
        if (r_v0 && free1) begin
            r_diff <= err_res.diff;
        end
        if (r_v1 && free2) begin
            r_pp <= n_pp;
            r_pi <= n_pi;
            r_pd <= n_pd;
        end
        if (r_v2 && adv3) begin
            r_drive_power <= n_drive_power;
            r_clamped     <= n_clamped;
        end
    end

    assign o_out_valid   = r_v3;
    assign o_drive_power = r_drive_power;
    assign o_clamped     = r_clamped;

    `HPID_ASSERT_SAME(a_stall_only_when_full, o_in_stall, r_v0 && r_v1 && r_v2 && r_v3)
    `HPID_ASSERT_SAME(a_err_in_range, r_v1,
        (r_err <= ERR_W'(ERR_MAX)) && (r_err >= -ERR_W'(ERR_MAX)))
    `HPID_ASSERT_NEXT(a_result_from_products, !r_v3 && !r_v2, !r_v3)

endmodule
